// ===== design/qph_pkg.sv =====
package qph_pkg;

   // Default table depth and the slot cap, one above the largest value of the 7-bit size register.
   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int MAX_SLOTS           = 128;

   localparam int SIZE_REG_W = 7;
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd11;
   localparam int MIN_SIZE = 11;

   localparam int KEY_W     = 31;
   localparam int POS_OUT_W = 6;

   // The remainder unit consumes the key two bits per step, MSB first.
   localparam int KEY_PAD_W = 32;
   localparam int MOD_BITS  = 2;
   localparam int MOD_STEPS = KEY_PAD_W / MOD_BITS;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MOD   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SETUP = 3'd2;
   localparam logic [STEP_W-1:0] STEP_READ  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_CHECK = 3'd4;
   localparam logic [STEP_W-1:0] STEP_WRITE = 3'd5;
   localparam logic [STEP_W-1:0] STEP_RESP  = 3'd6;

   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
   localparam logic [COND_W-1:0] COND_REQ      = 3'd1;
   localparam logic [COND_W-1:0] COND_MOD_LAST = 3'd2;
   localparam logic [COND_W-1:0] COND_STOP     = 3'd3;
   localparam logic [COND_W-1:0] COND_RSP      = 3'd4;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic setup;
      logic check;
      logic write;
      logic rsp_valid;
   } ctrl_type;

   typedef struct packed {
      logic mod_last;
      logic probe_stop;
   } status_type;

   typedef struct packed {
      logic [STEP_W-1:0] jump_true;
      logic [STEP_W-1:0] jump_false;
      logic [COND_W-1:0] cond;
      ctrl_type          ctrl;
   } uword_type;

   // Control program: one word per step, branch to jump_true when cond holds.
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w            = '0;
      w.jump_true  = STEP_IDLE;
      w.jump_false = STEP_IDLE;
      w.cond       = COND_ALWAYS;
      case (step)
         STEP_IDLE: begin
            w.cond       = COND_REQ;
            w.jump_true  = STEP_MOD;
            w.jump_false = STEP_IDLE;
            w.ctrl.load  = 1'b1;
         end
         STEP_MOD: begin
            w.cond          = COND_MOD_LAST;
            w.jump_true     = STEP_SETUP;
            w.jump_false    = STEP_MOD;
            w.ctrl.mod_step = 1'b1;
         end
         STEP_SETUP: begin
            w.jump_true  = STEP_READ;
            w.ctrl.setup = 1'b1;
         end
         STEP_READ: begin
            w.jump_true = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.cond       = COND_STOP;
            w.jump_true  = STEP_WRITE;
            w.jump_false = STEP_READ;
            w.ctrl.check = 1'b1;
         end
         STEP_WRITE: begin
            w.jump_true  = STEP_RESP;
            w.ctrl.write = 1'b1;
         end
         STEP_RESP: begin
            w.cond           = COND_RSP;
            w.jump_true      = STEP_IDLE;
            w.jump_false     = STEP_RESP;
            w.ctrl.rsp_valid = 1'b1;
         end
         default: begin
            w.jump_true  = STEP_IDLE;
            w.jump_false = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/qph_ram.sv =====
module qph_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/qph_sequencer.sv =====
module qph_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                rsp_tready,
   input  qph_pkg::status_type status,
   output qph_pkg::ctrl_type   ctrl
);

   logic [qph_pkg::STEP_W-1:0] step_ff;
   logic [qph_pkg::STEP_W-1:0] step_in;
   qph_pkg::uword_type         word;
   logic                       cond_true;

   assign word = qph_pkg::ucode_rom(step_ff);
   assign ctrl = word.ctrl;

   always_comb begin
      case (word.cond)
         qph_pkg::COND_ALWAYS:   cond_true = 1'b1;
         qph_pkg::COND_REQ:      cond_true = req_tvalid;
         qph_pkg::COND_MOD_LAST: cond_true = status.mod_last;
         qph_pkg::COND_STOP:     cond_true = status.probe_stop;
         qph_pkg::COND_RSP:      cond_true = rsp_tready;
         default:                cond_true = 1'b1;
      endcase
      step_in = cond_true ? word.jump_true : word.jump_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= qph_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

`ifndef SYNTHESIS
   // The slot write step is reached only from a probe check that stopped.
   assert property (@(posedge clock) disable iff (reset)
      step_ff == qph_pkg::STEP_WRITE |-> $past(step_ff) == qph_pkg::STEP_CHECK)
      else $error("write step entered without a finished probe");
`endif

endmodule

// ===== design/qph_datapath.sv =====
module qph_datapath #(
   parameter int TABLE_DEPTH = qph_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [qph_pkg::SIZE_REG_W-1:0]  csr_data,
   input  logic                            req_tvalid,
   input  logic                            req_command,
   input  logic [qph_pkg::KEY_W-1:0]       req_key,
   input  qph_pkg::ctrl_type               ctrl,
   output qph_pkg::status_type             status,
   output logic [qph_pkg::POS_OUT_W-1:0]   position,
   output logic                            found,
   output logic                            stored,
   output logic                            full_res
);

   // Slots beyond what the size register can select are never used.
   localparam int SLOT_COUNT = (TABLE_DEPTH < qph_pkg::MAX_SLOTS) ?
                               TABLE_DEPTH : qph_pkg::MAX_SLOTS;
   localparam int POS_W  = $clog2(SLOT_COUNT);
   localparam int SIZE_W = $clog2(SLOT_COUNT + 1);
   localparam int EXT_W  = SIZE_W + 1;
   localparam int SAT_W  = qph_pkg::SIZE_REG_W + 1;
   localparam logic [SAT_W-1:0] MIN_EXT  = SAT_W'(qph_pkg::MIN_SIZE);
   localparam logic [SAT_W-1:0] SLOT_EXT = SAT_W'(SLOT_COUNT);

   logic [qph_pkg::SIZE_REG_W-1:0] table_size_ff, table_size_in;
   logic [SLOT_COUNT-1:0]          valid_ff, valid_in;

   logic                           cmd_ff, cmd_in;
   logic [qph_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [qph_pkg::KEY_PAD_W-1:0]  key_sh_ff, key_sh_in;
   logic [qph_pkg::MOD_CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [POS_W-1:0]               rem_ff, rem_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [POS_W-1:0]               off_ff, off_in;
   logic [SIZE_W-1:0]              probe_ff, probe_in;
   logic                           found_ff, found_in;
   logic                           empty_ff, empty_in;

   logic [SAT_W-1:0]               size_sat;
   logic [SIZE_W-1:0]              size;
   logic [EXT_W-1:0]               size_ext;
   logic [POS_W-1:0]               rem_step;
   logic [EXT_W-1:0]               t;
   logic [EXT_W-1:0]               pos_sum;
   logic [EXT_W-1:0]               off_sum;
   logic [POS_W-1:0]               pos_next;
   logic [POS_W-1:0]               off_next;
   logic [qph_pkg::KEY_W-1:0]      rd_key;
   logic                           slot_valid;
   logic                           hit;
   logic                           probe_last;
   logic                           stop;
   logic                           wr_en;
   logic [POS_W+qph_pkg::POS_OUT_W-1:0] pos_wide;

   // Effective size is the register saturated into the usable range.
   always_comb begin
      size_sat = {1'b0, table_size_ff};
      if (size_sat < MIN_EXT) begin
         size_sat = MIN_EXT;
      end
      if (size_sat > SLOT_EXT) begin
         size_sat = SLOT_EXT;
      end
   end
   assign size     = size_sat[SIZE_W-1:0];
   assign size_ext = EXT_W'(size);

   // Restoring remainder, two key bits per step.
   always_comb begin
      rem_step = rem_ff;
      t        = '0;
      for (int i = 0; i < qph_pkg::MOD_BITS; i++) begin
         t = EXT_W'({rem_step, key_sh_ff[qph_pkg::KEY_PAD_W-1-i]});
         if (t >= size_ext) begin
            t = t - size_ext;
         end
         rem_step = t[POS_W-1:0];
      end
   end

   // Next probe slot and next offset (the offset plus two), both kept below the size.
   always_comb begin
      pos_sum = EXT_W'(pos_ff) + EXT_W'(off_ff);
      if (pos_sum >= size_ext) begin
         pos_sum = pos_sum - size_ext;
      end
      off_sum = EXT_W'(off_ff) + EXT_W'(2);
      if (off_sum >= size_ext) begin
         off_sum = off_sum - size_ext;
      end
   end
   assign pos_next = pos_sum[POS_W-1:0];
   assign off_next = off_sum[POS_W-1:0];

   assign slot_valid = valid_ff[pos_ff];
   assign hit        = slot_valid && (rd_key == key_ff);
   assign probe_last = (probe_ff == size);
   assign stop       = !slot_valid || hit || probe_last;
   assign wr_en      = ctrl.write && empty_ff && cmd_ff;

   assign status.mod_last   = (mod_cnt_ff == qph_pkg::MOD_CNT_W'(qph_pkg::MOD_STEPS - 1));
   assign status.probe_stop = stop;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_valid) begin
         table_size_in = csr_data;
      end
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[pos_ff] = 1'b1;
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      key_sh_in  = key_sh_ff;
      mod_cnt_in = mod_cnt_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      off_in     = off_ff;
      probe_in   = probe_ff;
      found_in   = found_ff;
      empty_in   = empty_ff;
      if (ctrl.load && req_tvalid) begin
         cmd_in     = req_command;
         key_in     = req_key;
         key_sh_in  = qph_pkg::KEY_PAD_W'(req_key);
         mod_cnt_in = '0;
         rem_in     = '0;
      end
      if (ctrl.mod_step) begin
         key_sh_in  = key_sh_ff << qph_pkg::MOD_BITS;
         mod_cnt_in = mod_cnt_ff + qph_pkg::MOD_CNT_W'(1);
         rem_in     = rem_step;
      end
      if (ctrl.setup) begin
         pos_in   = rem_ff;
         off_in   = POS_W'(1);
         probe_in = SIZE_W'(1);
      end
      if (ctrl.check) begin
         if (stop) begin
            found_in = hit;
            empty_in = !slot_valid;
         end else begin
            pos_in   = pos_next;
            off_in   = off_next;
            probe_in = probe_ff + SIZE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= qph_pkg::SIZE_RESET;
         valid_ff      <= '0;
      end else begin
         table_size_ff <= table_size_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      key_sh_ff  <= key_sh_in;
      mod_cnt_ff <= mod_cnt_in;
      rem_ff     <= rem_in;
      pos_ff     <= pos_in;
      off_ff     <= off_in;
      probe_ff   <= probe_in;
      found_ff   <= found_in;
      empty_ff   <= empty_in;
   end

   qph_ram #(
      .WIDTH(qph_pkg::KEY_W),
      .DEPTH(SLOT_COUNT)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff),
      .wr_data(key_ff),
      .rd_addr(pos_ff),
      .rd_data(rd_key)
   );

   assign pos_wide = {{qph_pkg::POS_OUT_W{1'b0}}, pos_ff};
   assign position = pos_wide[qph_pkg::POS_OUT_W-1:0];
   assign found    = found_ff;
   assign stored   = empty_ff && cmd_ff;
   assign full_res = !found_ff && !empty_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      ctrl.check |-> (EXT_W'(pos_ff) < size_ext) && (EXT_W'(off_ff) < size_ext))
      else $error("probe slot or offset outside the table");
   assert property (@(posedge clock) disable iff (reset)
      ctrl.check |-> (probe_ff != '0) && (probe_ff <= size))
      else $error("probe count out of range");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[pos_ff])
      else $error("insert overwrites an occupied slot");
`endif

endmodule

// ===== design/quadratic_probe_hash_table_unit.sv =====
// After a request word is taken, the sequencer runs the 16-step remainder loop and a
// setup step, then a read and a compare step for each of the P slots probed (1 to the
// table size), then a write step, and then offers the result. The next request word
// is taken only once the result has been taken.
// Reset (synchronous, active high) empties every slot at once and sets the size to 11.
// Slot keys are not cleared; an entry is compared only while its slot is valid.
module quadratic_probe_hash_table_unit #(
   parameter int TABLE_DEPTH = qph_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Size register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data,     // table_size
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [30:0] key, [31] zero fill
   input  logic [0:0]  req_tuser,    // [0] command: 0 find, 1 insert
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [5:0] position, [6] found, [7] stored,
                                     // [8] full_res, [15:9] zero fill
);

   // The sequencer steps through a short control program: take a request, run
   // the remainder loop, then alternate slot read and compare until the walk
   // stops, write the slot on a successful insert, and hold the result until
   // the consumer takes it. Only one request is in flight at a time.
   qph_pkg::ctrl_type   ctrl;
   qph_pkg::status_type status;

   logic [qph_pkg::POS_OUT_W-1:0] position;
   logic                          found;
   logic                          stored;
   logic                          full_res;

   qph_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .ctrl      (ctrl)
   );

   qph_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_command(req_tuser[0]),
      .req_key    (req_tdata[qph_pkg::KEY_W-1:0]),
      .ctrl       (ctrl),
      .status     (status),
      .position   (position),
      .found      (found),
      .stored     (stored),
      .full_res   (full_res)
   );

   // The size register takes a write in any cycle out of reset; it is meant to
   // be written only while no request is in flight. Neither input channel
   // reports ready while reset is held, since nothing is taken then.
   assign csr_ready  = !reset;
   assign req_tready = ctrl.load && !reset;
   assign rsp_tvalid = ctrl.rsp_valid;
   assign rsp_tdata  = {7'b0, full_res, stored, found, position};

endmodule

// ===== dv/tb_quadratic_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table_unit;

   localparam int SLOT_COUNT    = qph_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_WORDS  = 1230;
   // Idle cycles allowed before a size write once the last result word is in.
   localparam int SETTLE_CYCLES = 4;
   // The drain window is longer than the worst latency of a request at the full size.
   localparam int DRAIN_CYCLES  = 200;
   // The receiver refuses results for this long once, so the request side backs up.
   localparam int LONG_HOLD     = 500;
   localparam int HOLD_AFTER    = 150;

   typedef enum logic {
      CMD_FIND   = 1'b0,
      CMD_INSERT = 1'b1
   } command_type;

   typedef struct packed {
      logic [5:0] position;
      logic       found;
      logic       stored;
      logic       full_res;
   } lookup_outcome_type;

   // One line of the directed plan: either a size write or a request word,
   // with a hand-written outcome where it is obvious from the table contents.
   typedef struct packed {
      logic               is_size;
      logic [6:0]         size;
      command_type        cmd;
      logic [30:0]        key;
      logic               typed;
      lookup_outcome_type outcome;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;     // [30:0] key, [31] zero fill
   logic [0:0]  req_tuser  = '0;     // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [5:0] position, [6] found, [7] stored,
                                     // [8] full_res, [15:9] zero fill

   quadratic_probe_hash_table_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the table and of the size register.
   bit          slot_used [SLOT_COUNT];
   logic [30:0] slot_key  [SLOT_COUNT];
   logic [6:0]  size_reg;

   lookup_outcome_type pending_outcomes[$];
   logic [30:0]        key_pool[$];
   directed_row_type   plan[$];
   int unsigned        failures     = 0;
   int unsigned        results_seen = 0;
   int unsigned        burst_left   = 0;

   // The size register saturates into the range the table can actually use.
   function automatic int unsigned effective_size();
      int unsigned span;
      span = 32'(size_reg);
      if (span < qph_pkg::MIN_SIZE) span = qph_pkg::MIN_SIZE;
      if (span > SLOT_COUNT) span = SLOT_COUNT;
      return span;
   endfunction

   // Walks the probe sequence home, home+1, home+4, ... and applies an insert.
   // The walk ends on an empty slot, on a matching key, or after span probes.
   function automatic lookup_outcome_type probe_table(input command_type cmd,
                                                      input logic [30:0] key);
      int unsigned        span;
      int unsigned        slot;
      int unsigned        probe;
      bit                 hit;
      bit                 empty;
      lookup_outcome_type r;
      span  = effective_size();
      slot  = 32'(key) % span;
      probe = 1;
      hit   = 1'b0;
      empty = 1'b0;
      while (!hit && !empty && probe <= span) begin
         if (!slot_used[slot]) begin
            empty = 1'b1;
         end else if (slot_key[slot] == key) begin
            hit = 1'b1;
         end else begin
            if (probe < span) slot = (slot + 2 * probe - 1) % span;
            probe++;
         end
      end
      r          = '0;
      r.position = slot[5:0];
      r.found    = hit;
      r.full_res = !hit && !empty;
      if (empty && cmd == CMD_INSERT) begin
         slot_used[slot] = 1'b1;
         slot_key[slot]  = key;
         r.stored        = 1'b1;
      end
      return r;
   endfunction

   function automatic directed_row_type size_row(input logic [6:0] value);
      directed_row_type row;
      row         = '0;
      row.is_size = 1'b1;
      row.size    = value;
      return row;
   endfunction

   function automatic directed_row_type word_row(input command_type cmd, input logic [30:0] key);
      directed_row_type row;
      row     = '0;
      row.cmd = cmd;
      row.key = key;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input command_type cmd, input logic [30:0] key,
                                                  input logic [5:0] pos, input logic found,
                                                  input logic stored, input logic full_res);
      directed_row_type row;
      row         = word_row(cmd, key);
      row.typed   = 1'b1;
      row.outcome = '{position: pos, found: found, stored: stored, full_res: full_res};
      return row;
   endfunction

   // Keys are drawn from recent inserts, small numbers, chains that share a
   // home slot under the current size, and the full 31-bit range.
   function automatic logic [30:0] pick_key();
      logic [30:0] k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (key_pool.size() != 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else k = 31'($urandom_range(0, 200));
         end
         4, 5: k = 31'($urandom_range(0, 200));
         6, 7, 8: k = 31'($urandom_range(0, 15) + effective_size() * $urandom_range(0, 5000));
         default: k = 31'($urandom() & 32'h7FFF_FFFF);
      endcase
      return k;
   endfunction

   function automatic logic [6:0] pick_size();
      int unsigned primes[14] = '{11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61};
      case ($urandom_range(0, 5))
         0: return 7'd11;
         1: return 7'd64;
         2: return 7'($urandom_range(0, 127));
         default: return 7'(primes[$urandom_range(0, 13)]);
      endcase
   endfunction

   // After each accepted word the sender either carries on with its burst or
   // drops valid for a random gap. A zero gap keeps valid high throughout.
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic offer_word(input command_type cmd, input logic [30:0] key, input bit typed,
                             input lookup_outcome_type typed_outcome);
      lookup_outcome_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, key};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      predicted = probe_table(cmd, key);
      if (predicted.stored) begin
         key_pool.push_back(key);
         if (key_pool.size() > SLOT_COUNT) void'(key_pool.pop_front());
      end
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
      pace_sender();
   endtask

   // The size only changes while the table is idle: every result word in, and
   // a few more cycles so the control sequencer is back at rest.
   task automatic write_size(input logic [6:0] value);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = value;
   endtask

   // Result checker: every accepted word is matched against the oldest outcome.
   always @(posedge clock) begin : check_results
      lookup_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[5:0] != want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_tdata[5:0]);
               failures++;
            end
            if (rsp_tdata[6] != want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tdata[6]);
               failures++;
            end
            if (rsp_tdata[7] != want.stored) begin
               $error("stored: expected %0d, actual %0d", want.stored, rsp_tdata[7]);
               failures++;
            end
            if (rsp_tdata[8] != want.full_res) begin
               $error("full_res: expected %0d, actual %0d", want.full_res, rsp_tdata[8]);
               failures++;
            end
         end
      end
   end

   // Receiver: stretches of a repeating ready mask, some of them fully open,
   // and one long refusal once traffic is flowing.
   initial begin : result_sink
      bit [7:0]    ready_mask;
      int unsigned stretch;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
            stretch    = $urandom_range(16, 96);
            for (int i = 0; i < stretch; i++) begin
               rsp_tready <= ready_mask[i % 8];
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned      words_sent;
      int unsigned      phase_len;
      directed_row_type row;
      command_type      cmd;

      foreach (slot_used[i]) slot_used[i] = 1'b0;
      size_reg = qph_pkg::SIZE_RESET;

      // At size 11 the keys 0, 11, 22, ... all share home slot 0, and only six
      // slots lie on that probe sequence, so the seventh key finds no room.
      plan.push_back(typed_row(CMD_FIND,   0,  0, 0, 0, 0));
      plan.push_back(typed_row(CMD_INSERT, 0,  0, 0, 1, 0));
      plan.push_back(typed_row(CMD_INSERT, 0,  0, 1, 0, 0));
      plan.push_back(typed_row(CMD_FIND,   0,  0, 1, 0, 0));
      plan.push_back(typed_row(CMD_INSERT, 11, 1, 0, 1, 0));
      plan.push_back(typed_row(CMD_INSERT, 22, 4, 0, 1, 0));
      plan.push_back(typed_row(CMD_FIND,   33, 9, 0, 0, 0));
      plan.push_back(typed_row(CMD_INSERT, 33, 9, 0, 1, 0));
      plan.push_back(typed_row(CMD_INSERT, 44, 5, 0, 1, 0));
      plan.push_back(typed_row(CMD_INSERT, 55, 3, 0, 1, 0));
      plan.push_back(typed_row(CMD_INSERT, 66, 1, 0, 0, 1));
      plan.push_back(typed_row(CMD_FIND,   66, 1, 0, 0, 1));
      plan.push_back(typed_row(CMD_INSERT, 31'h7FFF_FFFF, 2, 0, 1, 0));
      plan.push_back(word_row(CMD_FIND,   31'h5555_5555));
      plan.push_back(word_row(CMD_INSERT, 31'h2AAA_AAAA));
      // Above the slot count the size saturates to 64.
      plan.push_back(size_row(7'd127));
      plan.push_back(typed_row(CMD_FIND,   0,  0,  1, 0, 0));
      plan.push_back(typed_row(CMD_INSERT, 63, 63, 0, 1, 0));
      plan.push_back(word_row(CMD_INSERT, 127));
      plan.push_back(word_row(CMD_FIND,   31'h7FFF_FFFF));
      // Below the minimum the size saturates to 11; the old slots stay put.
      plan.push_back(size_row(7'd0));
      plan.push_back(typed_row(CMD_FIND,   11, 1, 1, 0, 0));
      plan.push_back(word_row(CMD_INSERT, 77));
      plan.push_back(size_row(7'd64));
      plan.push_back(word_row(CMD_FIND,   1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_size) write_size(row.size);
         else offer_word(row.cmd, row.key, row.typed, row.outcome);
      end

      // Random phases, each under a fresh table size.
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         write_size(pick_size());
         phase_len = $urandom_range(40, 120);
         for (int n = 0; n < phase_len && words_sent < RANDOM_WORDS; n++) begin
            cmd = command_type'($urandom_range(0, 1));
            offer_word(cmd, pick_key(), 1'b0, '0);
            words_sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
